### sv/srsa_pkg.sv
`default_nettype none

package srsa_pkg;

  typedef enum logic [2:0] {
    CMD_MAP    = 3'd0,
    CMD_UNMAP  = 3'd1,
    CMD_SYNC   = 3'd2,
    CMD_STATUS = 3'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_FULL    = 2'd2,
    RC_STATE   = 2'd3
  } rc_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
  } ctl_t;

  localparam int CMD_W         = 3;
  localparam int SIZE_W        = 64;
  localparam int OWNER_W       = 32;
  localparam int SEL_W         = 32;
  localparam int ADDR_W        = 64;
  localparam int STRIDE_W      = 32;
  localparam int GRANT_W       = 4;
  localparam int TOTAL_W       = 5;
  localparam int SEQ_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_STRIDE = 1'd1;

  localparam logic [OWNER_W-1:0] OWNER_NONE = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

### sv/srsa_ctrl.sv
`default_nettype none

module srsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output srsa_pkg::ctl_t     ctl,
  output logic               busy,
  output logic               out_valid
);
  import srsa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctl.latch     = 1'b0;
    ctl.exec      = 1'b0;
    busy          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy          = 1'b1;
        ctl.exec      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/srsa_dp.sv
`default_nettype none

module srsa_dp #(
  parameter int NUM_ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire srsa_pkg::ctl_t                   ctl,
  input  wire logic                             cfg_we,
  input  wire logic [srsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [srsa_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [srsa_pkg::SIZE_W-1:0]      in_request_size,
  input  wire logic [srsa_pkg::OWNER_W-1:0]     in_owner_id,
  input  wire logic [srsa_pkg::SEL_W-1:0]       in_entry_select,
  output logic      [1:0]                       out_result_code,
  output logic      [srsa_pkg::GRANT_W-1:0]     out_granted_entry,
  output logic      [srsa_pkg::ADDR_W-1:0]      out_region_address,
  output logic      [srsa_pkg::TOTAL_W-1:0]     out_entry_total,
  output logic      [srsa_pkg::SEQ_W-1:0]       out_sequence_number
);
  import srsa_pkg::*;

  localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int PROD_W = IDX_W + STRIDE_W;
  localparam logic [SEL_W-1:0]   NUM_SEL = SEL_W'(NUM_ENTRIES);
  localparam logic [TOTAL_W-1:0] TOTAL   = TOTAL_W'(NUM_ENTRIES);

  logic [ADDR_W-1:0]   base_r;
  logic [STRIDE_W-1:0] stride_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [SIZE_W-1:0]   size_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [SEL_W-1:0]    sel_r;

  logic [NUM_ENTRIES-1:0] mapped_r;
  logic [SIZE_W-1:0]      size_mem  [NUM_ENTRIES];
  logic [OWNER_W-1:0]     owner_mem [NUM_ENTRIES];
  logic [SEQ_W-1:0]       seq_r;

  rc_t                 code_r;
  logic [IDX_W-1:0]    grant_r;
  logic                map_ok_r;
  logic                status_r;
  logic [PROD_W-1:0]   prod_r;

  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    sel_idx;
  logic                sel_ok;
  logic                sel_mapped;
  rc_t                 code_nxt;
  logic                map_ok_nxt;
  logic                unmap_ok;
  logic                status_nxt;
  logic [SEQ_W-1:0]    seq_nxt;
  logic [PROD_W-1:0]   prod_nxt;
  logic [IDX_W+GRANT_W-1:0] grant_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      stride_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHYS_BASE:   base_r   <= cfg_wdata;
        CFG_PHYS_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= in_cmd;
      size_r  <= in_request_size;
      owner_r <= in_owner_id;
      sel_r   <= in_entry_select;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (!mapped_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign sel_idx    = sel_r[IDX_W-1:0];
  assign sel_ok     = sel_r < NUM_SEL;
  assign sel_mapped = sel_ok && mapped_r[sel_idx];
  assign prod_nxt   = PROD_W'(free_idx) * PROD_W'(stride_r);

  always_comb begin
    code_nxt   = RC_OK;
    map_ok_nxt = 1'b0;
    unmap_ok   = 1'b0;
    status_nxt = 1'b0;
    seq_nxt    = seq_r;
    unique case (cmd_r)
      CMD_MAP: begin
        if (size_r == '0) begin
          code_nxt = RC_INVALID;
        end else if (!free_found) begin
          code_nxt = RC_FULL;
        end else begin
          map_ok_nxt = 1'b1;
          seq_nxt    = seq_r + SEQ_W'(1);
        end
      end
      CMD_UNMAP, CMD_SYNC: begin
        if (!sel_ok) begin
          code_nxt = RC_INVALID;
        end else if (!sel_mapped) begin
          code_nxt = RC_STATE;
        end else if (cmd_r == CMD_UNMAP) begin
          unmap_ok = 1'b1;
          seq_nxt  = seq_r + SEQ_W'(1);
        end else begin
          seq_nxt = seq_r + SEQ_W'(2);
        end
      end
      CMD_STATUS: begin
        status_nxt = 1'b1;
        seq_nxt    = seq_r + SEQ_W'(1);
      end
      default: begin
        code_nxt = RC_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= '0;
      seq_r    <= '0;
    end else if (ctl.exec) begin
      seq_r <= seq_nxt;
      if (map_ok_nxt) begin
        mapped_r[free_idx] <= 1'b1;
      end else if (unmap_ok) begin
        mapped_r[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && map_ok_nxt) begin
      size_mem[free_idx]  <= size_r;
      owner_mem[free_idx] <= owner_r;
    end else if (ctl.exec && unmap_ok) begin
      size_mem[sel_idx]  <= '0;
      owner_mem[sel_idx] <= OWNER_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      code_r   <= code_nxt;
      grant_r  <= map_ok_nxt ? free_idx : '0;
      map_ok_r <= map_ok_nxt;
      status_r <= status_nxt;
      prod_r   <= prod_nxt;
    end
  end

  assign grant_ext           = {{GRANT_W{1'b0}}, grant_r};
  assign out_result_code     = code_r;
  assign out_granted_entry   = grant_ext[GRANT_W-1:0];
  assign out_region_address  = map_ok_r ? base_r + ADDR_W'(prod_r) : '0;
  assign out_entry_total     = status_r ? TOTAL : '0;
  assign out_sequence_number = seq_r;

endmodule

`default_nettype wire

### sv/shared_region_slot_allocator.sv
// A command taken on start moves the FSM to ST_EXEC; there the result and out_valid are
// registered, and out_valid is then high for one cycle.
// The table update state holds busy, and no new command is taken while busy is high.
// The result is registered, so a new start is taken in the cycle the result is shown.
// The receiver cannot stall; out_valid marks each result for exactly one cycle.
// Reset (rst_n low, synchronous) frees all entries, clears the counter and layout regs.
`default_nettype none

module shared_region_slot_allocator #(
  parameter int NUM_ENTRIES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [srsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [srsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [srsa_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [srsa_pkg::SIZE_W-1:0]      in_request_size,
  input  wire logic [srsa_pkg::OWNER_W-1:0]     in_owner_id,
  input  wire logic [srsa_pkg::SEL_W-1:0]       in_entry_select,
  output logic                                  out_valid,
  output logic      [1:0]                       out_result_code,
  output logic      [srsa_pkg::GRANT_W-1:0]     out_granted_entry,
  output logic      [srsa_pkg::ADDR_W-1:0]      out_region_address,
  output logic      [srsa_pkg::TOTAL_W-1:0]     out_entry_total,
  output logic      [srsa_pkg::SEQ_W-1:0]       out_sequence_number
);
  import srsa_pkg::*;

  ctl_t ctl;

  srsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  srsa_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_cmd),
    .in_request_size     (in_request_size),
    .in_owner_id         (in_owner_id),
    .in_entry_select     (in_entry_select),
    .out_result_code     (out_result_code),
    .out_granted_entry   (out_granted_entry),
    .out_region_address  (out_region_address),
    .out_entry_total     (out_entry_total),
    .out_sequence_number (out_sequence_number)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted command did not enter execution");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result strobe without a preceding execution cycle");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code != RC_OK |->
      out_granted_entry == '0 && out_region_address == '0 && out_entry_total == '0)
    else $error("error result carries nonzero fields");

  a_seq_hold_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code != RC_OK |-> $stable(out_sequence_number))
    else $error("sequence counter moved on an error result");
`endif

endmodule

`default_nettype wire

### tb/shared_region_slot_allocator_test.sv
`default_nettype none

module shared_region_slot_allocator_test;
  import srsa_pkg::*;

  localparam int NUM_ENTRIES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNKNOWN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LAST_UNKNOWN = 3'd7;

  typedef struct {
    rc_t                 code;
    logic [GRANT_W-1:0]  grant;
    logic [ADDR_W-1:0]   addr;
    logic [TOTAL_W-1:0]  total;
    logic [SEQ_W-1:0]    seq;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        in_cmd;
  logic [SIZE_W-1:0]       in_request_size;
  logic [OWNER_W-1:0]      in_owner_id;
  logic [SEL_W-1:0]        in_entry_select;
  logic                    out_valid;
  logic [1:0]              out_result_code;
  logic [GRANT_W-1:0]      out_granted_entry;
  logic [ADDR_W-1:0]       out_region_address;
  logic [TOTAL_W-1:0]      out_entry_total;
  logic [SEQ_W-1:0]        out_sequence_number;

  logic [SIZE_W-1:0]       tbl_size [NUM_ENTRIES];
  logic [OWNER_W-1:0]      tbl_owner [NUM_ENTRIES];
  logic                    tbl_mapped [NUM_ENTRIES];
  logic [SEQ_W-1:0]        tbl_seq;
  logic [ADDR_W-1:0]       tbl_base;
  logic [STRIDE_W-1:0]     tbl_stride;

  reply_t                  pending_replies [$];
  reply_t                  head_reply;
  int                      mismatches = 0;

  shared_region_slot_allocator #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_request_size     (in_request_size),
    .in_owner_id         (in_owner_id),
    .in_entry_select     (in_entry_select),
    .out_valid           (out_valid),
    .out_result_code     (out_result_code),
    .out_granted_entry   (out_granted_entry),
    .out_region_address  (out_region_address),
    .out_entry_total     (out_entry_total),
    .out_sequence_number (out_sequence_number)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic clear_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_size[i] = '0;
      tbl_owner[i] = OWNER_NONE;
      tbl_mapped[i] = 1'b0;
    end
    tbl_seq = '0;
    tbl_base = '0;
    tbl_stride = '0;
  endtask

  task automatic predict_reply(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                               input logic [OWNER_W-1:0] owner, input logic [SEL_W-1:0] sel);
    reply_t r;
    int     slot;
    r.code = RC_OK;
    r.grant = '0;
    r.addr = '0;
    r.total = '0;
    slot = -1;
    case (cmd)
      CMD_MAP: begin
        if (size == '0) begin
          r.code = RC_INVALID;
        end else begin
          for (int i = NUM_ENTRIES - 1; i >= 0; i--)
            if (!tbl_mapped[i]) slot = i;
          if (slot < 0) begin
            r.code = RC_FULL;
          end else begin
            tbl_size[slot] = size;
            tbl_owner[slot] = owner;
            tbl_mapped[slot] = 1'b1;
            r.grant = slot[GRANT_W-1:0];
            r.addr = tbl_base + 64'(slot) * 64'(tbl_stride);
            tbl_seq = tbl_seq + 1;
          end
        end
      end
      CMD_UNMAP, CMD_SYNC: begin
        if (sel >= NUM_ENTRIES) begin
          r.code = RC_INVALID;
        end else if (!tbl_mapped[sel]) begin
          r.code = RC_STATE;
        end else if (cmd == CMD_UNMAP) begin
          tbl_size[sel] = '0;
          tbl_owner[sel] = OWNER_NONE;
          tbl_mapped[sel] = 1'b0;
          tbl_seq = tbl_seq + 1;
        end else begin
          tbl_seq = tbl_seq + 2;
        end
      end
      CMD_STATUS: begin
        tbl_seq = tbl_seq + 1;
        r.total = TOTAL_W'(NUM_ENTRIES);
      end
      default: begin
        r.code = RC_INVALID;
      end
    endcase
    r.seq = tbl_seq;
    pending_replies.push_back(r);
  endtask

  // leaves start high; the caller follows at once with another beat, a pause or a drain
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                          input logic [OWNER_W-1:0] owner, input logic [SEL_W-1:0] sel);
    start <= 1'b1;
    in_cmd <= cmd;
    in_request_size <= size;
    in_owner_id <= owner;
    in_entry_select <= sel;
    do @(posedge clk); while (busy);
    predict_reply(cmd, size, owner, sel);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_layout(input logic [ADDR_W-1:0] base, input logic [CFG_DATA_W-1:0] stride);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PHYS_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_PHYS_STRIDE;
    cfg_wdata <= stride;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_base = base;
    tbl_stride = stride[STRIDE_W-1:0];
  endtask

  task automatic test_idle_table();
    send_cmd(CMD_STATUS, '0, '0, '0);
    send_cmd(CMD_SYNC, '0, '0, '0);
    send_cmd(CMD_UNMAP, '1, '1, '0);
    send_cmd(CMD_MAP, '0, '1, '0);
    send_cmd(CMD_FIRST_UNKNOWN, '1, '0, '1);
    send_cmd(CMD_LAST_UNKNOWN, 64'd5, '0, '0);
    send_cmd(CMD_UNMAP, '0, '0, 32'(NUM_ENTRIES));
    send_cmd(CMD_SYNC, '0, '0, '1);
  endtask

  task automatic test_fill_and_wrap();
    drain_replies();
    set_layout(64'hFFFF_FFFF_FFFF_FFF0, 64'h0000_0000_FFFF_FFFF);
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_cmd(CMD_MAP, (i % 2) ? 64'd1 : '1, (i % 2) ? '1 : '0, '0);
    send_cmd(CMD_MAP, 64'd7, 32'd3, '0);
    send_cmd(CMD_SYNC, '0, '0, 32'(NUM_ENTRIES - 1));
    send_cmd(CMD_UNMAP, '0, '0, 32'(NUM_ENTRIES - 1));
    send_cmd(CMD_UNMAP, '0, '0, 32'(NUM_ENTRIES - 1));
    send_cmd(CMD_MAP, 64'd9, 32'd1, '0);
    send_cmd(CMD_SYNC, '0, '0, 32'(NUM_ENTRIES));
  endtask

  task automatic run_traffic(input int n_items, input int map_pct);
    logic [CMD_W-1:0]   cmd;
    logic [SIZE_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
    logic [SEL_W-1:0]   sel;
    int                 burst;
    int                 kind;
    burst = $urandom_range(1, 12);
    for (int n = 0; n < n_items; n++) begin
      size = {$urandom, $urandom};
      owner = $urandom;
      sel = $urandom;
      if ($urandom_range(0, 99) < map_pct) begin
        cmd = CMD_MAP;
        kind = $urandom_range(0, 9);
        if (kind == 0) size = '0;
        else if (kind < 4) size = 64'($urandom_range(1, 4096));
      end else begin
        kind = $urandom_range(0, 19);
        if (kind < 9) cmd = CMD_UNMAP;
        else if (kind < 15) cmd = CMD_SYNC;
        else if (kind < 17) cmd = CMD_STATUS;
        else cmd = CMD_W'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
        kind = $urandom_range(0, 9);
        if (kind == 0) sel = 32'($urandom_range(NUM_ENTRIES, 2 * NUM_ENTRIES));
        else if (kind > 1) sel = 32'($urandom_range(0, NUM_ENTRIES - 1));
      end
      send_cmd(cmd, size, owner, sel);
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 99) < 3) drain_replies();
        else pause_sender($urandom_range(0, 8));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      end
    end
  endtask

  task automatic test_random_traffic();
    drain_replies();
    set_layout('0, '0);
    run_traffic(200, 60);
    drain_replies();
    set_layout('1, '1);
    run_traffic(200, 75);
    drain_replies();
    set_layout({$urandom, $urandom}, 64'($urandom));
    run_traffic(200, 35);
    drain_replies();
    set_layout({$urandom, $urandom}, 64'($urandom_range(0, 255)));
    run_traffic(200, 55);
    drain_replies();
    set_layout('0, 64'h0000_0000_FFFF_FFFF);
    run_traffic(200, 50);
    drain_replies();
    set_layout({$urandom, $urandom}, {$urandom, $urandom});
    run_traffic(200, 65);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result: result_code %0d sequence_number %0d",
               out_result_code, out_sequence_number);
        mismatches++;
      end else begin
        head_reply = pending_replies.pop_front();
        if (out_result_code !== head_reply.code) begin
          $error("result_code: expected %0d, got %0d", head_reply.code, out_result_code);
          mismatches++;
        end
        if (out_granted_entry !== head_reply.grant) begin
          $error("granted_entry: expected %0d, got %0d", head_reply.grant, out_granted_entry);
          mismatches++;
        end
        if (out_region_address !== head_reply.addr) begin
          $error("region_address: expected %h, got %h", head_reply.addr, out_region_address);
          mismatches++;
        end
        if (out_entry_total !== head_reply.total) begin
          $error("entry_total: expected %0d, got %0d", head_reply.total, out_entry_total);
          mismatches++;
        end
        if (out_sequence_number !== head_reply.seq) begin
          $error("sequence_number: expected %0d, got %0d", head_reply.seq,
                 out_sequence_number);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stalled = 0;
      else stalled++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 1'b0;
    in_cmd = '0;
    in_request_size = '0;
    in_owner_id = '0;
    in_entry_select = '0;
    clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_table();
    test_fill_and_wrap();
    test_random_traffic();
    drain_replies();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
